// ===== hdl/bmhq_pkg.sv =====
// Package for the binary min-heap queue: command, status codes, FSM states.
// No dependencies.
`default_nettype none
package bmhq_pkg;
  localparam int unsigned KeyW = 31;
  localparam int unsigned CntW = 11;
  localparam int unsigned DefDepth = 1024;
  localparam int unsigned CapReset = 1024;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_DELMIN = 3'd1,
    CMD_FINDMIN = 3'd2,
    CMD_CLEAR = 3'd3,
    CMD_APPEND = 3'd4,
    CMD_HEAPIFY = 3'd5,
    CMD_RSVD6 = 3'd6,
    CMD_RSVD7 = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_FULL = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,      // read parent of pos, or place key at root
    S_UP_CMP,     // compare parent with key
    S_DEL_GET,    // capture root and last entry
    S_FIND_GET,   // capture root for find
    S_HP_RD,      // read node at pos for heapify
    S_HP_GET,     // capture node as sift key
    S_DN_RD,      // read both children of pos, or place key at leaf
    S_DN_CMP,     // pick child and compare
    S_DONE        // hand result to output register
  } state_e;
endpackage
`default_nettype wire

// ===== hdl/bmhq_ram.sv =====
// Generic dual-port RAM: one write port and two registered read ports.
// No dependencies.
`default_nettype none
module bmhq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_a_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic      [Width-1:0]         rdata_a_o,
  output logic      [Width-1:0]         rdata_b_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end
endmodule
`default_nettype wire

// ===== hdl/binary_min_heap_queue.sv =====
// Top level of the binary min-heap queue: sequencer and result register.
// Depends on bmhq_pkg and bmhq_ram.
//
// An array-backed binary min-heap of 31-bit keys, held in one RAM with two
// registered read ports and one write port. One command transaction is taken
// at a time and answers with one result transaction (key, status, count).
// Append, clear, refused and empty commands go straight to S_DONE, and find
// first captures the root. Insert climbs the heap and delete min, after
// capturing the root and the last entry, descends it, one level per sift step.
// Heapify sifts down every inner node: it fetches the node, moves it down
// level by level and places it. A sift step reads through a registered RAM
// port (S_UP_RD or S_DN_RD) and then compares (S_UP_CMP or S_DN_CMP).
// The next command is taken as soon as the sequencer is idle, even while the
// previous result is still stalled in the output register; the new result
// then waits in S_DONE until that register is free. Capacity must be
// written only while idle (not enforced here); limit is min(capacity, depth).
`default_nettype none
module binary_min_heap_queue #(
  parameter int unsigned HeapDepth = bmhq_pkg::DefDepth
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [bmhq_pkg::CntW-1:0] cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [2:0]                command_i,
  input  wire logic [bmhq_pkg::KeyW-1:0] key_value_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [bmhq_pkg::KeyW-1:0]      result_key_o,
  output logic [1:0]                     status_o,
  output logic [bmhq_pkg::CntW-1:0]      entry_count_o
);
  localparam int unsigned KW = bmhq_pkg::KeyW;
  localparam int unsigned CW = bmhq_pkg::CntW;
  localparam int unsigned AW = $clog2(HeapDepth);
  localparam int unsigned PW = AW + 2;   // position wide enough for 2*pos+2
  localparam int unsigned LW = (AW + 1 > CW) ? AW + 1 : CW;  // limit compare

  bmhq_pkg::state_e state_q, state_d;
  logic [CW-1:0] cap_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] hk_q, hk_d;       // heapify outer counter
  logic [KW-1:0] key_q, key_d;     // key being sifted
  logic [2:0]    cmd_q, cmd_d;
  logic [KW-1:0] wkey_q, wkey_d;   // result key of the running command
  logic [1:0]    wst_q, wst_d;     // status of the running command
  logic          ovld_q, ovld_d;
  logic [KW-1:0] okey_q, okey_d;
  logic [1:0]    ost_q, ost_d;
  logic [CW-1:0] ocnt_q, ocnt_d;

  logic          we;
  logic [AW-1:0] waddr, ra, rb;
  logic [KW-1:0] wdata, rda, rdb;
  logic          acc, full;
  logic [LW-1:0] lim;
  logic [PW-1:0] cntp, lastp, hkm, parent, lch, rch, child;
  logic [KW-1:0] cval;
  logic          has_r, take_r;
  bmhq_pkg::state_e sift_next;

  bmhq_ram #(.Width(KW), .Depth(HeapDepth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_a_i(ra), .raddr_b_i(rb), .rdata_a_o(rda), .rdata_b_o(rdb)
  );

  assign in_stall_o = (state_q != bmhq_pkg::S_IDLE);
  assign acc = in_valid_i && !in_stall_o;
  assign out_valid_o = ovld_q;
  assign result_key_o = okey_q;
  assign status_o = ost_q;
  assign entry_count_o = ocnt_q;

  assign lim = (LW'(cap_q) < LW'(HeapDepth)) ? LW'(cap_q) : LW'(HeapDepth);
  assign full = LW'(cnt_q) >= lim;
  assign cntp = PW'(cnt_q);
  assign lastp = cntp - PW'(1);
  assign hkm = hk_q - PW'(1);
  assign parent = (pos_q - PW'(1)) >> 1;
  assign lch = {pos_q[PW-2:0], 1'b1};
  assign rch = lch + PW'(1);
  assign has_r = rch < cntp;
  // ties keep the left child
  assign take_r = has_r && (rda > rdb);
  assign child = take_r ? rch : lch;
  assign cval = take_r ? rdb : rda;
  // after a sift: next heapify node, or finish
  assign sift_next = (cmd_q == bmhq_pkg::CMD_HEAPIFY && hk_q != '0) ?
                     bmhq_pkg::S_HP_RD : bmhq_pkg::S_DONE;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bmhq_pkg::S_IDLE: begin
        if (acc) begin
          case (command_i)
            bmhq_pkg::CMD_INSERT:
              state_d = full ? bmhq_pkg::S_DONE : bmhq_pkg::S_UP_RD;
            bmhq_pkg::CMD_DELMIN:
              state_d = (cnt_q == '0) ? bmhq_pkg::S_DONE : bmhq_pkg::S_DEL_GET;
            bmhq_pkg::CMD_FINDMIN:
              state_d = (cnt_q == '0) ? bmhq_pkg::S_DONE : bmhq_pkg::S_FIND_GET;
            bmhq_pkg::CMD_HEAPIFY:
              state_d = (cnt_q < CW'(2)) ? bmhq_pkg::S_DONE : bmhq_pkg::S_HP_RD;
            default: state_d = bmhq_pkg::S_DONE;
          endcase
        end
      end
      bmhq_pkg::S_UP_RD:
        state_d = (pos_q == '0) ? bmhq_pkg::S_DONE : bmhq_pkg::S_UP_CMP;
      bmhq_pkg::S_UP_CMP:
        state_d = (rda > key_q) ? bmhq_pkg::S_UP_RD : bmhq_pkg::S_DONE;
      bmhq_pkg::S_DEL_GET:  state_d = bmhq_pkg::S_DN_RD;
      bmhq_pkg::S_FIND_GET: state_d = bmhq_pkg::S_DONE;
      bmhq_pkg::S_HP_RD:    state_d = bmhq_pkg::S_HP_GET;
      bmhq_pkg::S_HP_GET:   state_d = bmhq_pkg::S_DN_RD;
      bmhq_pkg::S_DN_RD:
        state_d = (lch < cntp) ? bmhq_pkg::S_DN_CMP : sift_next;
      bmhq_pkg::S_DN_CMP:
        state_d = (key_q > cval) ? bmhq_pkg::S_DN_RD : sift_next;
      bmhq_pkg::S_DONE: begin
        if (!ovld_q || !out_stall_i) state_d = bmhq_pkg::S_IDLE;
      end
      default: state_d = bmhq_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cnt_d = cnt_q; pos_d = pos_q; hk_d = hk_q; key_d = key_q; cmd_d = cmd_q;
    wkey_d = wkey_q; wst_d = wst_q;
    ovld_d = ovld_q && out_stall_i; okey_d = okey_q; ost_d = ost_q; ocnt_d = ocnt_q;
    we = 1'b0; waddr = pos_q[AW-1:0]; wdata = key_q;
    ra = '0; rb = '0;
    case (state_q)
      bmhq_pkg::S_IDLE: begin
        if (acc) begin
          cmd_d = command_i; key_d = key_value_i; pos_d = cntp;
          wkey_d = '0; wst_d = bmhq_pkg::ST_OK;
          hk_d = cntp >> 1;
          case (command_i)
            bmhq_pkg::CMD_INSERT: begin
              if (full) wst_d = bmhq_pkg::ST_FULL;
              else cnt_d = cnt_q + CW'(1);
            end
            bmhq_pkg::CMD_APPEND: begin
              if (full) begin
                wst_d = bmhq_pkg::ST_FULL;
              end else begin
                cnt_d = cnt_q + CW'(1);
                we = 1'b1; waddr = cntp[AW-1:0]; wdata = key_value_i;
              end
            end
            bmhq_pkg::CMD_DELMIN: begin
              // root on port a, last entry on port b
              if (cnt_q == '0) begin
                wst_d = bmhq_pkg::ST_EMPTY;
              end else begin
                cnt_d = cnt_q - CW'(1);
                rb = lastp[AW-1:0];
              end
            end
            bmhq_pkg::CMD_FINDMIN: begin
              if (cnt_q == '0) wst_d = bmhq_pkg::ST_EMPTY;
            end
            bmhq_pkg::CMD_CLEAR: cnt_d = '0;
            default: ;
          endcase
        end
      end
      bmhq_pkg::S_UP_RD: begin
        if (pos_q == '0) we = 1'b1;
        else ra = parent[AW-1:0];
      end
      bmhq_pkg::S_UP_CMP: begin
        // move parent down, or place key at pos
        we = 1'b1;
        if (rda > key_q) begin
          wdata = rda; pos_d = parent;
        end
      end
      bmhq_pkg::S_DEL_GET: begin
        wkey_d = rda; key_d = rdb; pos_d = '0;
      end
      bmhq_pkg::S_FIND_GET: wkey_d = rda;
      bmhq_pkg::S_HP_RD: begin
        pos_d = hkm; hk_d = hkm;
        ra = hkm[AW-1:0];
      end
      bmhq_pkg::S_HP_GET: key_d = rda;
      bmhq_pkg::S_DN_RD: begin
        if (lch < cntp) begin
          ra = lch[AW-1:0]; rb = has_r ? rch[AW-1:0] : lch[AW-1:0];
        end else begin
          we = 1'b1;   // leaf: place key at pos
        end
      end
      bmhq_pkg::S_DN_CMP: begin
        // move child up, or place key at pos
        we = 1'b1;
        if (key_q > cval) begin
          wdata = cval; pos_d = child;
        end
      end
      bmhq_pkg::S_DONE: begin
        if (!ovld_q || !out_stall_i) begin
          ovld_d = 1'b1; okey_d = wkey_q; ost_d = wst_q; ocnt_d = cnt_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmhq_pkg::S_IDLE;
      cap_q <= CW'(bmhq_pkg::CapReset);
      cnt_q <= '0;
      pos_q <= '0;
      hk_q <= '0;
      key_q <= '0;
      cmd_q <= '0;
      wkey_q <= '0;
      wst_q <= bmhq_pkg::ST_OK;
      ovld_q <= 1'b0;
      okey_q <= '0;
      ost_q <= bmhq_pkg::ST_OK;
      ocnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      cnt_q <= cnt_d;
      pos_q <= pos_d;
      hk_q <= hk_d;
      key_q <= key_d;
      cmd_q <= cmd_d;
      wkey_q <= wkey_d;
      wst_q <= wst_d;
      ovld_q <= ovld_d;
      okey_q <= okey_d;
      ost_q <= ost_d;
      ocnt_q <= ocnt_d;
    end
  end

  // Assertions
  a_stall_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != bmhq_pkg::S_IDLE) |-> in_stall_o) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(result_key_o)
      && $stable(status_o) && $stable(entry_count_o)))
    else $error("stalled result changed");
  a_cnt_le_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LW'(cnt_q) <= LW'(HeapDepth)) else $error("count overflow");
  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == bmhq_pkg::ST_OK || status_o == bmhq_pkg::ST_FULL
      || status_o == bmhq_pkg::ST_EMPTY)) else $error("illegal status");
endmodule
`default_nettype wire

// ===== test/tb_binary_min_heap_queue.sv =====
// Testbench for binary_min_heap_queue: random and directed heap commands checked
// against a behavioral heap predictor. Depends on bmhq_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb_binary_min_heap_queue;
  localparam int unsigned KeyW = bmhq_pkg::KeyW;
  localparam int unsigned CntW = bmhq_pkg::CntW;
  localparam int unsigned Depth = bmhq_pkg::DefDepth;
  localparam int unsigned HoldCycles = 300;

  typedef struct packed {
    logic [2:0]      cmd;
    logic [KeyW-1:0] key;
  } heap_cmd_t;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [1:0]      st;
    logic [CntW-1:0] cnt;
  } heap_resp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CntW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] command_i = '0;
  logic [KeyW-1:0] key_value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [KeyW-1:0] result_key_o;
  logic [1:0] status_o;
  logic [CntW-1:0] entry_count_o;

  binary_min_heap_queue dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .command_i(command_i), .key_value_i(key_value_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .result_key_o(result_key_o), .status_o(status_o), .entry_count_o(entry_count_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Predictor state: a mirror of the heap.
  logic [KeyW-1:0] heap_mem [Depth];
  int unsigned     heap_cnt;
  int unsigned     cap_reg;

  heap_cmd_t  pending_cmds[$];
  heap_resp_t expected_resps[$];
  int         mismatches = 0;
  bit         quiet_in = 0;   // no idling on the sender side
  bit         quiet_out = 0;  // no idling on the receiver side
  bit         hold_req = 0;   // request a long receiver hold-off
  bit         hold_out = 0;   // receiver hold-off in progress
  int         hold_left = 0;
  bit         in_taken = 0;   // input transaction at the last rising edge

  function automatic int unsigned smaller_child(int unsigned pos);
    int unsigned c;
    c = 2 * pos + 1;
    if (c + 1 < heap_cnt && heap_mem[c] > heap_mem[c + 1]) c++;
    return c;
  endfunction

  function automatic heap_resp_t heap_apply(heap_cmd_t c);
    heap_resp_t r;
    int unsigned lim, pos, par, ch, k;
    logic [KeyW-1:0] last, t;
    r.key = '0;
    r.st = bmhq_pkg::ST_OK;
    lim = (cap_reg < Depth) ? cap_reg : Depth;
    case (c.cmd)
      bmhq_pkg::CMD_INSERT, bmhq_pkg::CMD_APPEND: begin
        if (heap_cnt >= lim) r.st = bmhq_pkg::ST_FULL;
        else if (c.cmd == bmhq_pkg::CMD_INSERT) begin
          pos = heap_cnt;
          while (pos > 0) begin
            par = (pos - 1) / 2;
            if (heap_mem[par] > c.key) begin
              heap_mem[pos] = heap_mem[par];
              pos = par;
            end else break;
          end
          heap_mem[pos] = c.key;
          heap_cnt++;
        end else begin
          heap_mem[heap_cnt] = c.key;
          heap_cnt++;
        end
      end
      bmhq_pkg::CMD_DELMIN: begin
        if (heap_cnt == 0) r.st = bmhq_pkg::ST_EMPTY;
        else begin
          r.key = heap_mem[0];
          heap_cnt--;
          last = heap_mem[heap_cnt];
          pos = 0;
          while (2 * pos + 1 < heap_cnt) begin
            ch = smaller_child(pos);
            if (last > heap_mem[ch]) begin
              heap_mem[pos] = heap_mem[ch];
              pos = ch;
            end else break;
          end
          heap_mem[pos] = last;
        end
      end
      bmhq_pkg::CMD_FINDMIN: begin
        if (heap_cnt == 0) r.st = bmhq_pkg::ST_EMPTY;
        else r.key = heap_mem[0];
      end
      bmhq_pkg::CMD_CLEAR: heap_cnt = 0;
      bmhq_pkg::CMD_HEAPIFY: begin
        for (k = heap_cnt / 2; k > 0; k--) begin
          pos = k - 1;
          while (2 * pos + 1 < heap_cnt) begin
            ch = smaller_child(pos);
            if (heap_mem[pos] > heap_mem[ch]) begin
              t = heap_mem[pos];
              heap_mem[pos] = heap_mem[ch];
              heap_mem[ch] = t;
              pos = ch;
            end else break;
          end
        end
      end
      default: ;
    endcase
    r.cnt = heap_cnt[CntW-1:0];
    return r;
  endfunction

  // Input transaction seen at the rising edge.
  always @(posedge clk_i) begin
    in_taken <= in_valid_i && !in_stall_o;
  end

  // Long receiver hold-off, counted here.
  always @(posedge clk_i) begin
    if (hold_out) begin
      if (hold_left <= 1) hold_out <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_out <= 1'b1;
      hold_left <= HoldCycles;
    end
  end

  // Driver: offers the next pending command, updates on falling edges.
  // A stalled transaction keeps valid and payload until it is taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        expected_resps.push_back(heap_apply(pending_cmds.pop_front()));
      end
      if (!in_valid_i || in_taken) begin
        if (pending_cmds.size() > 0 && (quiet_in || $urandom_range(99) >= 7)) begin
          in_valid_i <= 1'b1;
          command_i <= pending_cmds[0].cmd;
          key_value_i <= pending_cmds[0].key;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= hold_out || (!quiet_out && $urandom_range(99) < 7);
    end
  end

  // Monitor: checks each result transaction at the rising edge.
  always @(posedge clk_i) begin
    heap_resp_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{key: result_key_o, st: status_o, cnt: entry_count_o};
      if (expected_resps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result key=%0d st=%0d cnt=%0d",
                                       got.key, got.st, got.cnt);
      end else begin
        want = expected_resps.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp key=%0d st=%0d cnt=%0d, got key=%0d st=%0d cnt=%0d",
                     want.key, want.st, want.cnt, got.key, got.st, got.cnt);
        end
      end
    end
  end

  task automatic queue_cmd(logic [2:0] c, logic [KeyW-1:0] k);
    pending_cmds.push_back('{cmd: c, key: k});
  endtask

  task automatic drain();
    while (pending_cmds.size() > 0 || in_valid_i || expected_resps.size() > 0)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic set_capacity(int unsigned v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v[CntW-1:0];
    cap_reg = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random phase: mostly inserts and deletes, some bulk loads and heapify.
  task automatic random_cmds(int n, int unsigned keymax);
    int unsigned p;
    logic [KeyW-1:0] k;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(99);
      k = (keymax == 0) ? KeyW'($urandom) : KeyW'($urandom_range(keymax));
      if (p < 40) queue_cmd(bmhq_pkg::CMD_INSERT, k);
      else if (p < 68) queue_cmd(bmhq_pkg::CMD_DELMIN, k);
      else if (p < 78) queue_cmd(bmhq_pkg::CMD_FINDMIN, k);
      else if (p < 90) queue_cmd(bmhq_pkg::CMD_APPEND, k);
      else if (p < 96) queue_cmd(bmhq_pkg::CMD_HEAPIFY, k);
      else if (p < 98) queue_cmd(bmhq_pkg::CMD_CLEAR, k);
      else queue_cmd(($urandom_range(1) != 0) ? bmhq_pkg::CMD_RSVD7
                                              : bmhq_pkg::CMD_RSVD6, k);
    end
  endtask

  initial begin
    heap_cnt = 0;
    cap_reg = 1024;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty cases, key extremes, all codes, equal keys, full.
    set_capacity(3);
    queue_cmd(bmhq_pkg::CMD_DELMIN, '0);
    queue_cmd(bmhq_pkg::CMD_FINDMIN, '1);
    queue_cmd(bmhq_pkg::CMD_HEAPIFY, '0);
    queue_cmd(bmhq_pkg::CMD_INSERT, '1);
    queue_cmd(bmhq_pkg::CMD_INSERT, '0);
    queue_cmd(bmhq_pkg::CMD_INSERT, 31'd5);
    queue_cmd(bmhq_pkg::CMD_INSERT, 31'd7);
    queue_cmd(bmhq_pkg::CMD_APPEND, 31'd7);
    queue_cmd(bmhq_pkg::CMD_FINDMIN, '0);
    queue_cmd(bmhq_pkg::CMD_RSVD6, '1);
    queue_cmd(bmhq_pkg::CMD_RSVD7, '0);
    queue_cmd(bmhq_pkg::CMD_DELMIN, '0);
    queue_cmd(bmhq_pkg::CMD_DELMIN, '0);
    queue_cmd(bmhq_pkg::CMD_CLEAR, '0);
    queue_cmd(bmhq_pkg::CMD_APPEND, 31'd9);
    queue_cmd(bmhq_pkg::CMD_APPEND, 31'd9);
    queue_cmd(bmhq_pkg::CMD_APPEND, 31'd1);
    queue_cmd(bmhq_pkg::CMD_HEAPIFY, '0);
    queue_cmd(bmhq_pkg::CMD_DELMIN, '0);
    queue_cmd(bmhq_pkg::CMD_DELMIN, '0);
    drain();
    // Capacity equal to count, then zero.
    set_capacity(1);
    queue_cmd(bmhq_pkg::CMD_INSERT, 31'd4);
    queue_cmd(bmhq_pkg::CMD_DELMIN, '0);
    drain();
    set_capacity(0);
    queue_cmd(bmhq_pkg::CMD_APPEND, 31'd4);
    queue_cmd(bmhq_pkg::CMD_INSERT, 31'd4);
    drain();

    // Random, small keys for many ties, quiet sender and receiver.
    set_capacity(20);
    quiet_in = 1; quiet_out = 1;
    random_cmds(200, 15);
    drain();
    quiet_in = 0; quiet_out = 0;

    // Receiver holds off long while sender keeps offering.
    set_capacity(2047);
    random_cmds(200, 0);
    hold_req = 1;
    wait (hold_out);
    hold_req = 0;
    wait (!hold_out);
    drain();  // sender waits for every result

    set_capacity(1024);
    for (int i = 0; i < 470; i++) queue_cmd(bmhq_pkg::CMD_APPEND, KeyW'($urandom));
    queue_cmd(bmhq_pkg::CMD_HEAPIFY, '0);
    random_cmds(150, 0);
    drain();

    set_capacity(37);
    random_cmds(300, 1000);
    drain();

    if (mismatches == 0 && expected_resps.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/bmhq_pkg.sv
hdl/bmhq_ram.sv
hdl/binary_min_heap_queue.sv
test/tb_binary_min_heap_queue.sv
